@@ rtl/npos_pkg.sv @@
// npos_pkg: shared widths, register indexes and the step record for the
// naive pattern occurrence scanner. No dependencies.
package npos_pkg;

	localparam int BYTE_W        = 8;
	localparam int PATTERN_BYTES = 16;
	localparam int PATTERN_W     = PATTERN_BYTES * BYTE_W;
	localparam int LEN_W         = 5;
	localparam int POS_W         = 17;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 64;
	localparam int TDATA_W       = 72;

	localparam logic [POS_W-1:0] COUNT_LIMIT = '1;
	localparam logic [POS_W-1:0] NO_POS      = '1;

	localparam logic [CFG_IDX_W-1:0] REG_PAT_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN  = 2'd2;

	// what the window chain hands to the tally for one accepted item
	typedef struct packed {
		logic             hit;
		logic [POS_W-1:0] start;
		logic             last;
		logic             room;
	} step_t;

endpackage

@@ rtl/npos_cell.sv @@
// npos_cell: one window byte of the scanner chain and its compare against
// the pattern byte aligned to this place. Depends on npos_pkg.
module npos_cell #(
	parameter int IDX = 0
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                shift,
	input  logic [npos_pkg::BYTE_W-1:0]         din,
	input  logic [npos_pkg::PATTERN_W-1:0]      pattern,
	input  logic [npos_pkg::LEN_W-1:0]          plen,
	output logic [npos_pkg::BYTE_W-1:0]         dout,
	output logic                                ok
);

	logic [npos_pkg::BYTE_W-1:0] byte_q;
	logic [3:0]                  pidx;
	logic [npos_pkg::BYTE_W-1:0] pbyte;
	logic                        active;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (shift) begin
			byte_q <= din;
		end
	end

	// window place d meets pattern byte m-1-d
	assign pidx   = plen[3:0] - 4'd1 - 4'(IDX);
	assign pbyte  = pattern[pidx*npos_pkg::BYTE_W +: npos_pkg::BYTE_W];
	assign active = plen > npos_pkg::LEN_W'(IDX);
	assign ok     = !active || (din == pbyte);
	assign dout   = byte_q;

endmodule

@@ rtl/npos_tally.sv @@
// npos_tally: occurrence count, first and latest start, overflow flag and
// the output register of the scanner. Depends on npos_pkg.
module npos_tally (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          take,
	input  npos_pkg::step_t               st,
	output logic                          ready,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [npos_pkg::TDATA_W-1:0]  m_tdata,
	output logic                          m_tlast
);

	logic [npos_pkg::POS_W-1:0] count_q, first_q, last_q;
	logic                       first_vld_q, last_vld_q, ovf_q;
	logic [npos_pkg::POS_W-1:0] count_n, first_n, last_n;
	logic                       first_vld_n, last_vld_n, ovf_n;
	logic                       out_vld_q, out_last_q;
	logic [npos_pkg::TDATA_W-1:0] out_data_q, out_data_n;
	logic [npos_pkg::POS_W-1:0] match_start, first_out, last_out;

	assign ready = !out_vld_q || m_tready;

	always_comb begin
		count_n     = count_q;
		first_n     = first_q;
		first_vld_n = first_vld_q;
		last_n      = last_q;
		last_vld_n  = last_vld_q;
		ovf_n       = ovf_q || !st.room;
		if (st.hit) begin
			if (count_q != npos_pkg::COUNT_LIMIT) begin
				count_n = count_q + npos_pkg::POS_W'(1);
			end
			if (!first_vld_q) begin
				first_n     = st.start;
				first_vld_n = 1'b1;
			end
			last_n     = st.start;
			last_vld_n = 1'b1;
		end
		match_start = st.hit ? st.start : npos_pkg::NO_POS;
		first_out   = first_vld_n ? first_n : npos_pkg::NO_POS;
		last_out    = last_vld_n ? last_n : npos_pkg::NO_POS;
		// match_here, match_start, count, first, last, overflow, pad
		out_data_n  = {2'b00, ovf_n, last_out, first_out, count_n, match_start, st.hit};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			first_q     <= npos_pkg::NO_POS;
			first_vld_q <= 1'b0;
			last_q      <= npos_pkg::NO_POS;
			last_vld_q  <= 1'b0;
			ovf_q       <= 1'b0;
		end else if (take) begin
			if (st.last) begin
				count_q     <= '0;
				first_q     <= npos_pkg::NO_POS;
				first_vld_q <= 1'b0;
				last_q      <= npos_pkg::NO_POS;
				last_vld_q  <= 1'b0;
				ovf_q       <= 1'b0;
			end else begin
				count_q     <= count_n;
				first_q     <= first_n;
				first_vld_q <= first_vld_n;
				last_q      <= last_n;
				last_vld_q  <= last_vld_n;
				ovf_q       <= ovf_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (take) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_data_q <= out_data_n;
			out_last_q <= st.last;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

endmodule

@@ rtl/naive_pattern_occurrence_scan.sv @@
// naive_pattern_occurrence_scan: top level of the scanner, a chain of window
// cells, the pattern registers and the tally. Depends on npos_pkg,
// npos_cell and npos_tally.
//
//   channel  direction  handshake            payload
//   s_*      in         s_tvalid / s_tready  tdata text_byte, tlast end_of_text
//   m_*      out        m_tvalid / m_tready  tdata result fields, tlast text_done
//   cfg_*    in         cfg_valid/cfg_ready  cfg_index register, cfg_data value
//
// one item per cycle unless the sink stalls; an item's result appears in the cycle after
// it is taken, set by the window compare and tally update that share one register stage
// the output register holds a result while the sink stalls; a new item is
// taken in the same cycle the held result leaves
// reset clears the window, the counters and the pattern registers at once
// cfg_ready is always high
module naive_pattern_occurrence_scan #(
	parameter int MAX_PATTERN = 16,
	parameter int MAX_TEXT    = 65536
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [7:0]                         s_tdata,  // [7:0] text_byte
	input  logic                               s_tlast,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [0] match_here, [17:1] match_start, [34:18] occurrence_count,
	// [51:35] first_start, [68:52] last_start, [69] length_overflow, [71:70] zero
	output logic [npos_pkg::TDATA_W-1:0]       m_tdata,
	output logic                               m_tlast,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [npos_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [npos_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int NCELL = (MAX_PATTERN < npos_pkg::PATTERN_BYTES) ?
	                       MAX_PATTERN : npos_pkg::PATTERN_BYTES;
	localparam int PW    = $clog2(MAX_TEXT + 1);

	logic [npos_pkg::CFG_DATA_W-1:0] pat_low_q, pat_high_q;
	logic [npos_pkg::LEN_W-1:0]      plen_q;
	logic [PW-1:0]                   pos_q;
	logic                            take, room, shift, len_ok, all_ok;
	logic [npos_pkg::PATTERN_W-1:0]  pattern;
	logic [npos_pkg::BYTE_W-1:0]     chain [NCELL+1];
	logic [NCELL-1:0]                cell_ok;
	npos_pkg::step_t                 st;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q  <= '0;
			pat_high_q <= '0;
			plen_q     <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				npos_pkg::REG_PAT_LOW:  pat_low_q  <= cfg_data;
				npos_pkg::REG_PAT_HIGH: pat_high_q <= cfg_data;
				npos_pkg::REG_PAT_LEN:  plen_q     <= cfg_data[npos_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign pattern = {pat_high_q, pat_low_q};
	assign take    = s_tvalid && s_tready;
	assign room    = pos_q < PW'(MAX_TEXT);
	assign shift   = take && room;

	assign chain[0] = s_tdata;

	for (genvar g = 0; g < NCELL; g++) begin : g_cell
		npos_cell #(
			.IDX(g)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (shift),
			.din    (chain[g]),
			.pattern(pattern),
			.plen   (plen_q),
			.dout   (chain[g+1]),
			.ok     (cell_ok[g])
		);
	end

	assign all_ok = &cell_ok;
	// no match until the current text holds at least a pattern's worth of bytes
	assign len_ok = (plen_q != '0) && (plen_q <= npos_pkg::LEN_W'(NCELL)) &&
	                ((PW+1)'(pos_q) + (PW+1)'(1) >= (PW+1)'(plen_q));

	assign st.hit   = room && len_ok && all_ok;
	assign st.start = npos_pkg::POS_W'(pos_q + PW'(1) - PW'(plen_q));
	assign st.last  = s_tlast;
	assign st.room  = room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (take) begin
			if (s_tlast) begin
				pos_q <= '0;
			end else if (room) begin
				pos_q <= pos_q + PW'(1);
			end
		end
	end

	npos_tally u_tally (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.st      (st),
		.ready   (s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

endmodule
